// ===== sv/cfq_pkg.sv =====
// Shared types and constants for the command frame receive queue.
// No dependencies; compile before every other file of the block.
`default_nettype none

package cfq_pkg;

  // Default sizing, handed to the top level parameters
  localparam int DEF_SLOTS       = 8;
  localparam int DEF_FRAME_BYTES = 16;
  localparam int DEF_COMMANDS    = 8;

  // Fixed field widths
  localparam int BYTE_W     = 8;
  localparam int OFF_W      = 4;
  localparam int REQ_W      = 2;
  localparam int CODE_W     = 2;
  localparam int LEN_W      = 5;
  localparam int NUM_LEN    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_RX      = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [CODE_W-1:0] {
    ST_OK       = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_BAD_CODE = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [CODE_W-1:0] {
    RING_EMPTY = 2'd0,
    RING_SOME  = 2'd1,
    RING_FULL  = 2'd2
  } ring_t;

endpackage

`default_nettype wire

// ===== sv/cfq_in_if.sv =====
// Request channel of the command frame receive queue.
// Depends on cfq_pkg for field widths.
`default_nettype none

interface cfq_in_if import cfq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] rx_byte;
  logic [OFF_W-1:0]  read_offset;

  modport source (output valid, req_type, rx_byte, read_offset, input ready);
  modport sink   (input valid, req_type, rx_byte, read_offset, output ready);
endinterface

`default_nettype wire

// ===== sv/cfq_out_if.sv =====
// Result channel of the command frame receive queue.
// Depends on cfq_pkg for field widths.
`default_nettype none

interface cfq_out_if import cfq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              wake;
  logic [BYTE_W-1:0] read_byte;
  logic [CODE_W-1:0] ring_state;
  logic [CODE_W-1:0] status;

  modport source (output valid, wake, read_byte, ring_state, status, input ready);
  modport sink   (input valid, wake, read_byte, ring_state, status, output ready);
endinterface

`default_nettype wire

// ===== sv/cfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/command_frame_receive_queue_core.sv =====
// Command frame receive queue, top level.
// Depends on cfq_pkg, cfq_in_if, cfq_out_if and cfq_ram.
//
// Usage:
//   in_if  : one request per transfer. req_type 0 pushes a received byte,
//            1 reads read_offset of the oldest stored frame, 2 releases the
//            oldest frame, 3 does nothing.
//   out_if : exactly one result transfer per request, in request order:
//            wake (byte completed a frame), read_byte, ring_state after the
//            request (0 empty, 1 holds frames, 2 full) and status.
//   cfg_*  : write-only length table, one 5-bit register per command code,
//            written while no request is outstanding.
// The first byte of a frame is its code; the code's length register gives
// the whole frame length (0 taken as 1, clipped to FRAME_BYTES). Bytes that
// would start a frame while the ring is full are dropped; codes at or above
// COMMANDS are dropped and flagged.
// The result is registered and appears in the cycle after its request transfer.
// Throughput: one request per cycle unless stalled; all state updates for a
// request happen in the accepting cycle, and the frame store read uses the
// one registered RAM read port, whose data lands with the result register.
// Reset (rst_n low, synchronous): ring empty, no frame open, length table 1.
// The frame store is not cleared; a read past a frame's length returns old data.
// Receiver stall: the result register holds (and the RAM read data with it);
// a new request is taken in the same cycle the held result transfers.
`default_nettype none

module command_frame_receive_queue_core
  import cfq_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int FRAME_BYTES = DEF_FRAME_BYTES,
  parameter int COMMANDS    = DEF_COMMANDS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cfq_in_if.sink                     in_if,
  cfq_out_if.source                  out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int DEPTH  = SLOTS * FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  // Length table
  logic [LEN_W-1:0] len_code_r [NUM_LEN];

  // Ring and assembly state
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;
  ring_t             fill_r, fill_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic              open_r, open_nxt;
  logic [LEN_W-1:0]  exp_len_r, exp_len_nxt;

  // Result register
  logic              out_valid_r;
  logic              wake_r, wake_nxt;
  ring_t             ring_r;
  status_t           status_r, status_nxt;
  logic              rd_flag_r, rd_flag_nxt;

  // Frame store ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  logic              in_fire;
  req_t              req;
  logic [LEN_W-1:0]  code_len;
  logic [LEN_W-1:0]  pos_cur;
  logic [LEN_W-1:0]  exp_cur;
  logic [LEN_W-1:0]  pos_inc;
  logic [SLOT_W-1:0] ws_next_slot;
  logic [SLOT_W-1:0] rs_next_slot;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;
  assign req         = req_t'(in_if.req_type);

  // Clip the code's length into 1..FRAME_BYTES
  always_comb begin
    code_len = len_code_r[in_if.rx_byte[CFG_IDX_W-1:0]];
    if (code_len == '0) begin
      code_len = LEN_W'(1);
    end else if (int'(code_len) > FRAME_BYTES) begin
      code_len = LEN_W'(FRAME_BYTES);
    end
  end

  assign pos_cur = open_r ? pos_r : '0;
  assign exp_cur = open_r ? exp_len_r : code_len;
  assign pos_inc = pos_cur + LEN_W'(1);

  assign ws_next_slot = (write_slot_r == SLOT_W'(SLOTS - 1)) ? '0 : write_slot_r + SLOT_W'(1);
  assign rs_next_slot = (read_slot_r == SLOT_W'(SLOTS - 1)) ? '0 : read_slot_r + SLOT_W'(1);

  assign mem_waddr = ADDR_W'(32'(write_slot_r) * 32'(FRAME_BYTES) + 32'(pos_cur));
  assign mem_raddr = ADDR_W'(32'(read_slot_r) * 32'(FRAME_BYTES) + 32'(in_if.read_offset));

  // Request decode: all state changes of one request in one pass
  always_comb begin
    write_slot_nxt = write_slot_r;
    read_slot_nxt  = read_slot_r;
    fill_nxt       = fill_r;
    pos_nxt        = pos_r;
    open_nxt       = open_r;
    exp_len_nxt    = exp_len_r;
    wake_nxt       = 1'b0;
    status_nxt     = ST_OK;
    rd_flag_nxt    = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    unique case (req)
      REQ_RX: begin
        if (fill_r == RING_FULL) begin
          status_nxt = ST_DROPPED;
        end else if (!open_r && (int'(in_if.rx_byte) >= COMMANDS)) begin
          status_nxt = ST_BAD_CODE;
        end else begin
          mem_we      = in_fire;
          exp_len_nxt = exp_cur;
          if (pos_inc >= exp_cur) begin
            // Frame complete: advance the write slot and raise wake
            wake_nxt       = 1'b1;
            open_nxt       = 1'b0;
            pos_nxt        = '0;
            write_slot_nxt = ws_next_slot;
            fill_nxt       = (ws_next_slot == read_slot_r) ? RING_FULL : RING_SOME;
          end else begin
            open_nxt = 1'b1;
            pos_nxt  = pos_inc;
          end
        end
      end
      REQ_READ: begin
        if (fill_r == RING_EMPTY) begin
          status_nxt = ST_EMPTY;
        end else if (int'(in_if.read_offset) < FRAME_BYTES) begin
          rd_flag_nxt = 1'b1;
          mem_re      = in_fire;
        end
      end
      REQ_RELEASE: begin
        if (fill_r == RING_EMPTY) begin
          status_nxt = ST_EMPTY;
        end else begin
          read_slot_nxt = rs_next_slot;
          fill_nxt      = (rs_next_slot == write_slot_r) ? RING_EMPTY : RING_SOME;
        end
      end
      REQ_NONE: begin
      end
      default: begin
      end
    endcase
  end

  cfq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_if.rx_byte),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Length table writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEN; i++) begin
        len_code_r[i] <= LEN_W'(1);
      end
    end else if (cfg_we) begin
      len_code_r[cfg_index] <= cfg_wdata;
    end
  end

  // Ring state: advance only on a request transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      read_slot_r  <= '0;
      fill_r       <= RING_EMPTY;
      pos_r        <= '0;
      open_r       <= 1'b0;
      exp_len_r    <= LEN_W'(1);
    end else if (in_fire) begin
      write_slot_r <= write_slot_nxt;
      read_slot_r  <= read_slot_nxt;
      fill_r       <= fill_nxt;
      pos_r        <= pos_nxt;
      open_r       <= open_nxt;
      exp_len_r    <= exp_len_nxt;
    end
  end

  // Result register: load on request transfer, drop on result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      wake_r    <= wake_nxt;
      ring_r    <= fill_nxt;
      status_r  <= status_nxt;
      rd_flag_r <= rd_flag_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.wake       = wake_r;
  assign out_if.read_byte  = rd_flag_r ? mem_rdata : '0;
  assign out_if.ring_state = ring_r;
  assign out_if.status     = status_r;

  // A completed frame never carries an error status
  a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && wake_r) |-> (status_r == ST_OK))
    else $error("wake raised with error status");

  // Full and empty both mean the two slot pointers meet
  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == RING_FULL || fill_r == RING_EMPTY) |-> (write_slot_r == read_slot_r))
    else $error("ring pointers disagree with fill state");

  // No frame can be open while the ring is full
  a_open_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (fill_r != RING_FULL))
    else $error("frame open on full ring");

  // An open frame has not yet reached its length
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (pos_r < exp_len_r))
    else $error("byte position past frame length");

endmodule

`default_nettype wire
